### rtl/wl1024a_pkg.sv
// ----------------------------------------------------------------------------
// wl1024a_pkg
// Shared types and constants of the WELL1024a multi-stream generator.
// ----------------------------------------------------------------------------
package wl1024a_pkg;

  localparam int unsigned WORD_W = 32;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_GEN  = 1'b1;

  localparam logic [4:0] TAP1     = 5'd3;
  localparam logic [4:0] TAP2     = 5'd24;
  localparam logic [4:0] TAP3     = 5'd10;
  localparam logic [4:0] LAST_OFS = 5'd31;

  localparam int unsigned SHR_T1 = 8;
  localparam int unsigned SHL_T2 = 19;
  localparam int unsigned SHL_T3 = 14;
  localparam int unsigned SHL_Z0 = 11;
  localparam int unsigned SHL_Z1 = 7;
  localparam int unsigned SHL_Z2 = 13;

  typedef struct packed {
    logic        action;
    logic [1:0]  stream;
    logic [4:0]  word_index;
    logic [31:0] seed_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  out_stream;
    logic [31:0] random_word;
  } out_word_t;

  function automatic logic [WORD_W-1:0] mix_shr(input logic [WORD_W-1:0] v,
                                                input int unsigned t);
    return v ^ (v >> t);
  endfunction

  function automatic logic [WORD_W-1:0] mix_shl(input logic [WORD_W-1:0] v,
                                                input int unsigned t);
    return v ^ (v << t);
  endfunction

endpackage

### rtl/well1024a_random_generator.sv
// ----------------------------------------------------------------------------
// well1024a_random_generator
// Multi-stream WELL1024a generator with seed loading.
//
//   channel | direction | payload                  | handshake
//   --------+-----------+--------------------------+---------------------
//   in      | input     | in_word_t (load or gen)  | in_valid_i/in_stall_o
//   out     | output    | out_word_t (stream,word) | out_valid_o/out_stall_i
//
// One item per cycle while in_stall_o is low; a generate's word goes from
// stage 1 to the output register and can wait in stage 1 behind a stall.
// State words sit in an even and an odd bank, each read at two addresses per
// cycle; the word at the stream position is held in a per-stream head.
// After reset a clearing pass zeroes the NUM_STREAMS*16 used rows of each bank.
// Apart from the clearing pass, the input stalls only while a generate waits
// behind a stalled output.
// ----------------------------------------------------------------------------
module well1024a_random_generator #(
  parameter int NUM_STREAMS = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  wl1024a_pkg::in_word_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output wl1024a_pkg::out_word_t out_data_o
);

  localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int AW = SW + 4;
  localparam int ROWS = NUM_STREAMS * 16;
  localparam int WW = wl1024a_pkg::WORD_W;

  // per-stream position and head word
  logic [4:0]    pos_q  [NUM_STREAMS];
  logic [WW-1:0] head_q [NUM_STREAMS];

  // clearing pass
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  // stage 1
  logic          s1_valid_q;
  logic          s1_gen_q;
  logic [1:0]    s1_stream_q;
  logic [4:0]    s1_pos_q;
  logic [4:0]    s1_idx_q;
  logic [WW-1:0] s1_seed_q;
  logic          s1_sel_q;
  logic [WW-1:0] s1_head_q;
  logic [1:0]    s1_hit_q [4];
  logic [WW-1:0] fwd0_q;
  logic [WW-1:0] fwd1_q;

  logic                   out_valid_q;
  wl1024a_pkg::out_word_t out_data_q;

  logic          s1_adv;
  logic          in_take;
  logic          in_ok;
  logic [SW-1:0] in_sidx;
  logic [SW-1:0] s1_sidx;
  logic [4:0]    in_p;
  logic [4:0]    pos_d;
  logic [4:0]    ra [4];
  logic          in_sel;
  logic [WW-1:0] head_d;
  logic [1:0]    hit_d [4];

  logic [WW-1:0] b0_rd0, b0_rd1, b1_rd0, b1_rd1;
  logic [WW-1:0] mem_v [4];
  logic [WW-1:0] v [4];
  logic [WW-1:0] z0, z1, z2, v0_new, new_v, s1_head_new;

  logic          w0_en, w1_en;
  logic [4:0]    w0_word, w1_word;
  logic [WW-1:0] w0_data, w1_data;

  logic          b_we [2];
  logic [AW-1:0] b_waddr [2];
  logic [WW-1:0] b_wdata [2];

  // handshake
  assign s1_adv     = !s1_valid_q || !s1_gen_q || !out_valid_q || !out_stall_i;
  assign in_stall_o = clr_busy_q || !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_ok      = 32'(in_data_i.stream) < 32'(NUM_STREAMS);
  assign in_sidx    = SW'(in_data_i.stream);
  assign s1_sidx    = SW'(s1_stream_q);

  // read addresses of the incoming word
  always_comb begin
    in_p  = (in_data_i.action == wl1024a_pkg::ACT_GEN) ? pos_q[in_sidx] : 5'd0;
    ra[0] = in_p + wl1024a_pkg::TAP1;
    ra[1] = (in_data_i.action == wl1024a_pkg::ACT_GEN) ? in_p + wl1024a_pkg::TAP3
                                                         : 5'd0;
    ra[2] = in_p + wl1024a_pkg::TAP2;
    ra[3] = in_p + wl1024a_pkg::LAST_OFS;
    in_sel = ra[1][0];
    pos_d  = (in_data_i.action == wl1024a_pkg::ACT_GEN) ? ra[3] : 5'd0;
  end

  // stage 1 writes, also the forwarding sources
  always_comb begin
    w0_en   = s1_valid_q;
    w0_word = s1_gen_q ? s1_pos_q : s1_idx_q;
    w0_data = s1_gen_q ? v0_new : s1_seed_q;
    w1_en   = s1_valid_q && s1_gen_q;
    w1_word = s1_pos_q + wl1024a_pkg::LAST_OFS;
    w1_data = new_v;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hit_d[i][0] = w0_en && (s1_stream_q == in_data_i.stream) && (w0_word == ra[i]);
      hit_d[i][1] = w1_en && (s1_stream_q == in_data_i.stream) && (w1_word == ra[i]);
    end
    head_d = (s1_valid_q && (s1_stream_q == in_data_i.stream)) ? s1_head_new
                                                               : head_q[in_sidx];
  end

  // banks
  wl1024a_bank #(.AddrW(AW)) u_bank_even (
    .clk_i    (clk_i),
    .re_i     (in_take),
    .raddr0_i (in_sel ? {in_sidx, ra[0][4:1]} : {in_sidx, ra[1][4:1]}),
    .raddr1_i (in_sel ? {in_sidx, ra[3][4:1]} : {in_sidx, ra[2][4:1]}),
    .rdata0_o (b0_rd0),
    .rdata1_o (b0_rd1),
    .we_i     (b_we[0]),
    .waddr_i  (b_waddr[0]),
    .wdata_i  (b_wdata[0])
  );

  wl1024a_bank #(.AddrW(AW)) u_bank_odd (
    .clk_i    (clk_i),
    .re_i     (in_take),
    .raddr0_i (in_sel ? {in_sidx, ra[1][4:1]} : {in_sidx, ra[0][4:1]}),
    .raddr1_i (in_sel ? {in_sidx, ra[2][4:1]} : {in_sidx, ra[3][4:1]}),
    .rdata0_o (b1_rd0),
    .rdata1_o (b1_rd1),
    .we_i     (b_we[1]),
    .waddr_i  (b_waddr[1]),
    .wdata_i  (b_wdata[1])
  );

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      b_we[b]    = 1'b0;
      b_waddr[b] = clr_addr_q;
      b_wdata[b] = '0;
      priority if (clr_busy_q) begin
        b_we[b] = 1'b1;
      end else if (s1_adv && w0_en && (w0_word[0] == b[0])) begin
        b_we[b]    = 1'b1;
        b_waddr[b] = {s1_sidx, w0_word[4:1]};
        b_wdata[b] = w0_data;
      end else if (s1_adv && w1_en && (w1_word[0] == b[0])) begin
        b_we[b]    = 1'b1;
        b_waddr[b] = {s1_sidx, w1_word[4:1]};
        b_wdata[b] = w1_data;
      end
    end
  end

  // recurrence
  always_comb begin
    mem_v[0] = s1_sel_q ? b0_rd0 : b1_rd0;
    mem_v[1] = s1_sel_q ? b1_rd0 : b0_rd0;
    mem_v[2] = s1_sel_q ? b1_rd1 : b0_rd1;
    mem_v[3] = s1_sel_q ? b0_rd1 : b1_rd1;
    for (int i = 0; i < 4; i++) begin
      priority if (s1_hit_q[i][0]) begin
        v[i] = fwd0_q;
      end else if (s1_hit_q[i][1]) begin
        v[i] = fwd1_q;
      end else begin
        v[i] = mem_v[i];
      end
    end
    z0 = v[3];
    z1 = s1_head_q ^ wl1024a_pkg::mix_shr(v[0], wl1024a_pkg::SHR_T1);
    z2 = wl1024a_pkg::mix_shl(v[2], wl1024a_pkg::SHL_T2)
       ^ wl1024a_pkg::mix_shl(v[1], wl1024a_pkg::SHL_T3);
    v0_new = z1 ^ z2;
    new_v  = wl1024a_pkg::mix_shl(z0, wl1024a_pkg::SHL_Z0)
           ^ wl1024a_pkg::mix_shl(z1, wl1024a_pkg::SHL_Z1)
           ^ wl1024a_pkg::mix_shl(z2, wl1024a_pkg::SHL_Z2);
    s1_head_new = s1_gen_q ? new_v : ((s1_idx_q == 5'd0) ? s1_seed_q : v[1]);
  end

  // clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(ROWS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // per-stream position and head
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STREAMS; i++) begin
        pos_q[i]  <= '0;
        head_q[i] <= '0;
      end
    end else begin
      if (s1_adv && s1_valid_q) begin
        head_q[s1_sidx] <= s1_head_new;
      end
      if (in_take && in_ok) begin
        pos_q[in_sidx] <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= in_ok;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_gen_q    <= (in_data_i.action == wl1024a_pkg::ACT_GEN);
      s1_stream_q <= in_data_i.stream;
      s1_pos_q    <= in_p;
      s1_idx_q    <= in_data_i.word_index;
      s1_seed_q   <= in_data_i.seed_value;
      s1_sel_q    <= in_sel;
      s1_head_q   <= head_d;
      s1_hit_q    <= hit_d;
      fwd0_q      <= w0_data;
      fwd1_q      <= w1_data;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_valid_q && s1_gen_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q && s1_gen_q) begin
      out_data_q.out_stream  <= s1_stream_q;
      out_data_q.random_word <= new_v;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### rtl/wl1024a_bank.sv
// ----------------------------------------------------------------------------
// wl1024a_bank
// State word bank: two registered read ports, one write port.
// ----------------------------------------------------------------------------
module wl1024a_bank #(
  parameter int AddrW = 6
) (
  input  logic                             clk_i,
  input  logic                             re_i,
  input  logic [AddrW-1:0]                 raddr0_i,
  input  logic [AddrW-1:0]                 raddr1_i,
  output logic [wl1024a_pkg::WORD_W-1:0]   rdata0_o,
  output logic [wl1024a_pkg::WORD_W-1:0]   rdata1_o,
  input  logic                             we_i,
  input  logic [AddrW-1:0]                 waddr_i,
  input  logic [wl1024a_pkg::WORD_W-1:0]   wdata_i
);

  localparam int Depth = 2 ** AddrW;

  logic [wl1024a_pkg::WORD_W-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

### test/well1024a_random_generator_tb.sv
// ----------------------------------------------------------------------------
// well1024a_random_generator_tb
// Drives seed loads and generate words into the multi-stream WELL1024a
// generator. A scoreboard tracks every stream's state words and position,
// predicts each random word, and checks the results in order.
// ----------------------------------------------------------------------------
module well1024a_random_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STREAMS   = 4;
  localparam int NUM_ITEMS = 2000;

  class well_word_board;
    logic [31:0]            words [STREAMS][32];
    logic [4:0]             head  [STREAMS];
    wl1024a_pkg::out_word_t expected_words [$];
    int                     errors;

    function new();
      errors = 0;
      foreach (words[s, i]) words[s][i] = '0;
      foreach (head[s]) head[s] = '0;
    endfunction

    function logic [31:0] advance_stream(int s);
      logic [4:0]  p, last, t1, t2, t3;
      logic [31:0] z0, z1, z2, a, b, c;
      p    = head[s];
      last = p + 5'd31;
      t1   = p + 5'd3;
      t2   = p + 5'd24;
      t3   = p + 5'd10;
      z0   = words[s][last];
      a    = words[s][t1];
      b    = words[s][t2];
      c    = words[s][t3];
      z1   = words[s][p] ^ a ^ (a >> 8);
      z2   = b ^ (b << 19) ^ c ^ (c << 14);
      words[s][p]    = z1 ^ z2;
      words[s][last] = z0 ^ (z0 << 11) ^ z1 ^ (z1 << 7) ^ z2 ^ (z2 << 13);
      head[s] = last;
      return words[s][last];
    endfunction

    function void note_word(wl1024a_pkg::in_word_t w);
      wl1024a_pkg::out_word_t e;
      if (w.stream >= STREAMS) return;
      if (w.action == wl1024a_pkg::ACT_LOAD) begin
        words[w.stream][w.word_index] = w.seed_value;
        head[w.stream] = '0;
      end else begin
        e.out_stream  = w.stream;
        e.random_word = advance_stream(w.stream);
        expected_words.push_back(e);
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
      errors++;
    endtask

    task check_word(wl1024a_pkg::out_word_t got);
      wl1024a_pkg::out_word_t want;
      if (expected_words.size() == 0) begin
        report("unexpected word", got.random_word, '0);
        return;
      end
      want = expected_words.pop_front();
      if (got.out_stream !== want.out_stream)
        report("out_stream", 32'(got.out_stream), 32'(want.out_stream));
      if (got.random_word !== want.random_word)
        report("random_word", got.random_word, want.random_word);
    endtask
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  wl1024a_pkg::in_word_t  in_data_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  wl1024a_pkg::out_word_t out_data_o;

  bit             quiet;
  int             items_sent;
  well_word_board board = new();

  well1024a_random_generator #(
    .NUM_STREAMS(STREAMS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("well1024a_random_generator_tb NOT OK");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] pick_seed();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hffff_ffff;
    return $urandom;
  endfunction

  task automatic send_word(input wl1024a_pkg::in_word_t w);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    board.note_word(w);
    items_sent++;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load_word(input int s, input int idx, input logic [31:0] seed);
    wl1024a_pkg::in_word_t w;
    w.action     = wl1024a_pkg::ACT_LOAD;
    w.stream     = 2'(s);
    w.word_index = 5'(idx);
    w.seed_value = seed;
    send_word(w);
  endtask

  task automatic gen_word(input int s);
    wl1024a_pkg::in_word_t w;
    w.action     = wl1024a_pkg::ACT_GEN;
    w.stream     = 2'(s);
    w.word_index = 5'($urandom);
    w.seed_value = $urandom;
    send_word(w);
  endtask

  // output side: check accepted words, stall in random bursts
  initial begin : drain
    int hold;
    out_stall_i = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) board.check_word(out_data_o);
      if (hold > 0) hold--;
      else hold = gap_len();
      out_stall_i <= (hold > 0);
    end
  end

  initial begin : stimulus
    wl1024a_pkg::in_word_t w;
    int                    s;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    quiet      = 1'b0;
    items_sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    gen_word(0);
    gen_word(3);
    load_word(1, 0, 32'hffff_ffff);
    load_word(1, 31, 32'hffff_ffff);
    load_word(1, 3, 32'h8000_0001);
    load_word(1, 24, 32'haaaa_aaaa);
    load_word(1, 10, 32'h5555_5555);
    gen_word(1);
    gen_word(1);
    gen_word(1);
    load_word(2, 17, 32'h0000_0000);
    load_word(2, 5, 32'hffff_ffff);
    gen_word(2);
    load_word(1, 7, 32'h1234_5678);
    gen_word(1);
    gen_word(1);
    load_word(0, 31, 32'hffff_ffff);
    gen_word(0);
    gen_word(0);
    load_word(3, 0, 32'h0000_0001);
    gen_word(3);
    gen_word(3);

    while (items_sent < NUM_ITEMS) begin
      quiet = ($urandom_range(0, 7) == 0);
      s = $urandom_range(0, STREAMS - 1);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          for (int i = 0; i < 32; i++) load_word(s, i, pick_seed());
          repeat ($urandom_range(1, 48))
            gen_word(($urandom_range(0, 3) == 0) ? $urandom_range(0, STREAMS - 1) : s);
        end
        7, 8: begin
          repeat ($urandom_range(1, 20)) gen_word($urandom_range(0, STREAMS - 1));
        end
        default: begin
          repeat ($urandom_range(1, 10)) begin
            w.action     = 1'($urandom);
            w.stream     = 2'($urandom);
            w.word_index = 5'($urandom);
            w.seed_value = pick_seed();
            send_word(w);
          end
        end
      endcase
    end

    in_valid_i <= 1'b0;
    while (board.expected_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (board.errors == 0 && board.expected_words.size() == 0) begin
      $display("well1024a_random_generator_tb OK");
    end else begin
      $display("well1024a_random_generator_tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
rtl/wl1024a_pkg.sv
rtl/wl1024a_bank.sv
rtl/well1024a_random_generator.sv
test/well1024a_random_generator_tb.sv
